>>> sv/assert_macros.svh
// assertion helpers for the associative memory
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> sv/amnm_pkg.sv
`default_nettype none
package amnm_pkg;
   localparam int ENTRIES_DEFAULT = 16;
   localparam logic [15:0] MISS_WORD = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_EXACT   = 3'd0,
      OP_NEAREST = 3'd1,
      OP_STORE   = 3'd2,
      OP_DELETE  = 3'd3,
      OP_LOOKUP  = 3'd4,
      OP_UPDATE  = 3'd5,
      OP_READ    = 3'd6,
      OP_CLEAR   = 3'd7
   } op_type;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_MISS  = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // one entry as it travels around the ring
   typedef struct packed {
      logic        valid;
      logic [15:0] key;
      logic [15:0] word;
      logic [7:0]  age;
   } entry_type;

   // write-back command applied to the entry passing the head of the ring
   typedef struct packed {
      logic        wr;      // replace entry with new_entry
      logic        age_inc; // increment age if valid
      entry_type   new_entry;
   } cell_cmd_type;

   function automatic logic [4:0] popcount16(input logic [15:0] x);
      logic [4:0] n;
      n = '0;
      for (int b = 0; b < 16; b++) n = n + 5'(x[b]);
      return n;
   endfunction
endpackage
`default_nettype wire

>>> sv/amnm_cell.sv
`default_nettype none
module amnm_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire logic                 clear,
   input  wire amnm_pkg::entry_type  d_in,
   output amnm_pkg::entry_type       d_out
);
   import amnm_pkg::*;
   entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         ent_ff <= '0;
      end else if (shift) begin
         ent_ff <= d_in;
      end
   end
   assign d_out = ent_ff;
endmodule
`default_nettype wire

>>> sv/associative_memory_with_nearest_match_unit.sv
// an accepted request is served in two turns of the ring of entry cells, which
// rotates one entry per cycle past a single compare and write-back point:
// one full turn to scan and one to write back; no new request is taken
// until the result has been registered
// a waiting result stalls the next request until it is taken
// reset (synchronous, active high) clears all entries and counters at once
`default_nettype none
module associative_memory_with_nearest_match_unit #(
   parameter int ENTRIES = amnm_pkg::ENTRIES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_kind,
   input  wire logic [15:0] req_pattern,
   input  wire logic [15:0] req_value,
   input  wire logic [3:0]  req_slot,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [3:0]       rsp_entry_index,
   output logic [15:0]      rsp_entry_data,
   output logic [15:0]      rsp_entry_pattern,
   output logic [4:0]       rsp_distance,
   output logic [31:0]      rsp_hit_total,
   output logic [31:0]      rsp_miss_total,
   output logic [31:0]      rsp_search_total,
   output logic [31:0]      rsp_store_total
);
   import amnm_pkg::*;
   `include "assert_macros.svh"

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_DONE} state_type;

   state_type state_ff;
   logic [CW-1:0] cnt_ff;     // position of the entry at the head
   op_type kind_ff;
   logic [15:0] pat_ff, val_ff;
   logic [3:0] slot_ff;

   // scan results
   logic          key_hit_ff, free_hit_ff, near_hit_ff, read_hit_ff;
   logic [IW-1:0] key_idx_ff, free_idx_ff, near_idx_ff, old_idx_ff;
   logic [4:0]    near_d_ff;
   logic [7:0]    old_age_ff;
   entry_type     key_ent_ff, near_ent_ff, read_ent_ff;

   // apply pass decisions
   logic          tgt_ff;     // a write-back target exists
   logic [IW-1:0] tgt_idx_ff;
   entry_type     tgt_ent_ff;
   logic          age_ff;     // increment ages in apply pass

   logic [31:0] hit_ff, miss_ff, search_ff, store_ff;
   logic        out_v_ff;
   logic [1:0]  o_st_ff;
   logic [3:0]  o_idx_ff;
   logic [15:0] o_data_ff, o_pat_ff;
   logic [4:0]  o_dist_ff;

   // ring of cells
   entry_type ring [ENTRIES];
   entry_type head, head_in;
   logic shift, clr;
   cell_cmd_type cmd;
   logic [IW-1:0] pos;

   assign head = ring[ENTRIES-1];
   assign pos  = cnt_ff[IW-1:0];
   assign shift = (state_ff == S_SCAN) || (state_ff == S_APPLY);
   assign clr  = 1'b0;

   // write-back target, decided from the scan results and held through apply
   logic          tgt_in, age_in;
   logic [IW-1:0] tgt_idx_in;
   entry_type     tgt_ent_in;
   always_comb begin
      tgt_in = 1'b0; age_in = 1'b0; tgt_idx_in = '0;
      tgt_ent_in = '{valid: 1'b1, key: pat_ff, word: val_ff, age: 8'd0};
      case (kind_ff)
         OP_LOOKUP: begin
            if (key_hit_ff && key_ent_ff.word != MISS_WORD) begin
               tgt_in = 1'b1; age_in = 1'b1; tgt_idx_in = key_idx_ff;
               tgt_ent_in = key_ent_ff; tgt_ent_in.age = 8'd0;
            end
         end
         OP_STORE, OP_UPDATE: begin
            if (key_hit_ff) begin
               tgt_in = 1'b1; tgt_idx_in = key_idx_ff;
            end else if (free_hit_ff) begin
               tgt_in = 1'b1; tgt_idx_in = free_idx_ff;
            end else if (kind_ff == OP_UPDATE) begin
               tgt_in = 1'b1; tgt_idx_in = old_idx_ff;
            end
         end
         OP_DELETE: begin
            if (key_hit_ff) begin
               tgt_in = 1'b1; tgt_idx_in = key_idx_ff;
               tgt_ent_in = '{valid: 1'b0, key: 16'd0, word: 16'd0, age: key_ent_ff.age};
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      cmd = '0;
      if (state_ff == S_APPLY) begin
         // entry 0 passes the head before the decision is registered
         if (cnt_ff == '0) begin
            cmd.wr = tgt_in && (tgt_idx_in == pos);
            cmd.age_inc = age_in && !cmd.wr;
            cmd.new_entry = tgt_ent_in;
         end else begin
            cmd.wr = tgt_ff && (tgt_idx_ff == pos);
            cmd.age_inc = age_ff && !cmd.wr;
            cmd.new_entry = tgt_ent_ff;
         end
      end
      head_in = head;
      if (cmd.wr) begin
         head_in = cmd.new_entry;
      end else if (cmd.age_inc && head.valid) begin
         head_in.age = head.age + 8'd1;
      end
   end

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      amnm_cell u_cell (
         .clock (clock),
         .reset (reset || (state_ff == S_DONE && kind_ff == OP_CLEAR)),
         .shift (shift),
         .clear (clr),
         .d_in  ((g == 0) ? head_in : ring[(g == 0) ? 0 : g-1]),
         .d_out (ring[g])
      );
   end

   logic [4:0] d_cur;
   assign d_cur = popcount16(pat_ff ^ head.key);

   assign req_stall = (state_ff != S_IDLE) || (out_v_ff && rsp_stall);

   // result and counters at end of scan
   logic [1:0]  o_st_in;
   logic [3:0]  o_idx_in;
   logic [15:0] o_data_in, o_pat_in;
   logic [4:0]  o_dist_in;
   logic [31:0] hit_in, miss_in, search_in, store_in;
   always_comb begin
      o_dist_in = '0; o_st_in = ST_DONE; o_idx_in = '0;
      o_data_in = MISS_WORD; o_pat_in = '0;
      hit_in = hit_ff; miss_in = miss_ff; search_in = search_ff; store_in = store_ff;
      case (kind_ff)
         OP_EXACT, OP_LOOKUP: begin
            search_in = search_ff + 32'd1;
            if (key_hit_ff) begin
               hit_in = hit_ff + 32'd1;
               o_idx_in = 4'(key_idx_ff);
               o_data_in = key_ent_ff.word; o_pat_in = key_ent_ff.key;
            end else begin
               miss_in = miss_ff + 32'd1; o_st_in = ST_MISS;
            end
         end
         OP_NEAREST: begin
            search_in = search_ff + 32'd1;
            if (near_hit_ff) begin
               hit_in = hit_ff + 32'd1;
               o_idx_in = 4'(near_idx_ff); o_dist_in = near_d_ff;
               o_data_in = near_ent_ff.word; o_pat_in = near_ent_ff.key;
            end else begin
               miss_in = miss_ff + 32'd1; o_st_in = ST_MISS;
            end
         end
         OP_STORE, OP_UPDATE: begin
            store_in = store_ff + 32'd1;
            if (tgt_in) begin
               o_idx_in = 4'(tgt_idx_in);
               o_data_in = val_ff; o_pat_in = pat_ff;
            end else begin
               o_st_in = ST_FULL;
            end
         end
         OP_DELETE: begin
            if (key_hit_ff) begin
               o_idx_in = 4'(key_idx_ff);
               o_data_in = key_ent_ff.word; o_pat_in = key_ent_ff.key;
            end else begin
               o_st_in = ST_MISS;
            end
         end
         OP_READ: begin
            o_idx_in = slot_ff;
            if (read_hit_ff) begin
               o_data_in = read_ent_ff.word; o_pat_in = read_ent_ff.key;
            end else begin
               o_st_in = ST_EMPTY; o_pat_in = MISS_WORD;
            end
         end
         default: begin
            o_data_in = '0;
            hit_in = '0; miss_in = '0; search_in = '0; store_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_v_ff <= 1'b0;
         hit_ff <= '0; miss_ff <= '0; search_ff <= '0; store_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (out_v_ff && !rsp_stall) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  kind_ff <= op_type'(req_kind);
                  pat_ff <= req_pattern; val_ff <= req_value; slot_ff <= req_slot;
                  key_hit_ff <= 1'b0; free_hit_ff <= 1'b0; near_hit_ff <= 1'b0;
                  read_hit_ff <= 1'b0;
                  near_d_ff <= 5'd17; old_age_ff <= '0; old_idx_ff <= '0;
                  key_idx_ff <= '0; free_idx_ff <= '0; near_idx_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // the head holds entry pos this cycle
               if (head.valid && head.key == pat_ff && !key_hit_ff) begin
                  key_hit_ff <= 1'b1; key_idx_ff <= pos; key_ent_ff <= head;
               end
               if (!head.valid && !free_hit_ff) begin
                  free_hit_ff <= 1'b1; free_idx_ff <= pos;
               end
               if (head.valid && d_cur < near_d_ff) begin
                  near_hit_ff <= 1'b1; near_d_ff <= d_cur;
                  near_idx_ff <= pos; near_ent_ff <= head;
               end
               if (head.valid && head.age > old_age_ff) begin
                  old_age_ff <= head.age; old_idx_ff <= pos;
               end
               if (int'(pos) == int'(slot_ff) && head.valid) begin
                  read_hit_ff <= 1'b1; read_ent_ff <= head;
               end
               if (cnt_ff == CW'(ENTRIES - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= S_APPLY;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_APPLY: begin
               if (cnt_ff == CW'(ENTRIES - 1)) begin
                  cnt_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  cnt_ff <= cnt_ff + CW'(1);
               end
            end
            S_DONE: begin
               out_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff == S_APPLY && cnt_ff == '0) begin
            o_dist_ff <= o_dist_in; o_st_ff <= o_st_in; o_idx_ff <= o_idx_in;
            o_data_ff <= o_data_in; o_pat_ff <= o_pat_in;
            hit_ff <= hit_in; miss_ff <= miss_in;
            search_ff <= search_in; store_ff <= store_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= 1'b0; age_ff <= 1'b0;
      end else if (state_ff == S_APPLY && cnt_ff == '0) begin
         tgt_ff <= tgt_in; age_ff <= age_in;
      end
      if (state_ff == S_APPLY && cnt_ff == '0) begin
         tgt_idx_ff <= tgt_idx_in; tgt_ent_ff <= tgt_ent_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_status = o_st_ff;
   assign rsp_entry_index = o_idx_ff;
   assign rsp_entry_data = o_data_ff;
   assign rsp_entry_pattern = o_pat_ff;
   assign rsp_distance = o_dist_ff;
   assign rsp_hit_total = hit_ff;
   assign rsp_miss_total = miss_ff;
   assign rsp_search_total = search_ff;
   assign rsp_store_total = store_ff;

   `ASSERT_ALWAYS(a_busy_stall, clock, reset, (state_ff != S_IDLE) |-> req_stall, "busy not stalled")
   `ASSERT_NEXT(a_done_out, clock, reset, state_ff == S_DONE, rsp_valid, "result not shown")
   `ASSERT_ALWAYS(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped")
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import amnm_pkg::*;

   localparam int NSLOT = 16;
   localparam int WATCH_LIMIT = 20000;

   typedef struct {
      op_type      kind;
      logic [15:0] pattern;
      logic [15:0] value;
      logic [3:0]  slot;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [3:0]  index;
      logic [15:0] data;
      logic [15:0] pattern;
      logic [4:0]  distance;
      logic [31:0] hits, misses, searches, stores;
   } answer_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_kind = '0;
   logic [15:0] req_pattern = '0, req_value = '0;
   logic [3:0] req_slot = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_status;
   logic [3:0] rsp_entry_index;
   logic [15:0] rsp_entry_data, rsp_entry_pattern;
   logic [4:0] rsp_distance;
   logic [31:0] rsp_hit_total, rsp_miss_total, rsp_search_total, rsp_store_total;

   associative_memory_with_nearest_match_unit u_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // table shadow
   logic        tbl_valid [NSLOT];
   logic [15:0] tbl_key [NSLOT];
   logic [15:0] tbl_word [NSLOT];
   logic [7:0]  tbl_age [NSLOT];
   logic [31:0] n_hit, n_miss, n_search, n_store;

   request_type pending_reqs[$];
   answer_type  expected_answers[$];
   int errors = 0;
   int accepted = 0, answered = 0;
   bit stim_done = 0;
   int idle_cycles = 0;
   int op_seen [8];

   function automatic void wipe_table();
      for (int i = 0; i < NSLOT; i++) begin
         tbl_valid[i] = 0; tbl_key[i] = 0; tbl_word[i] = 0; tbl_age[i] = 0;
      end
      n_hit = 0; n_miss = 0; n_search = 0; n_store = 0;
   endfunction

   function automatic int slot_of_key(logic [15:0] key);
      for (int i = 0; i < NSLOT; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return i;
      return -1;
   endfunction

   function automatic int hamming(logic [15:0] x);
      int n = 0;
      for (int b = 0; b < 16; b++) n += x[b];
      return n;
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      int k, best, d;
      logic [7:0] top;
      a.status = ST_DONE; a.index = '0; a.data = MISS_WORD; a.pattern = '0; a.distance = '0;
      case (r.kind)
         OP_EXACT, OP_LOOKUP: begin
            n_search++;
            k = slot_of_key(r.pattern);
            if (k < 0) begin
               n_miss++; a.status = ST_MISS;
            end else begin
               n_hit++;
               a.index = 4'(k); a.data = tbl_word[k]; a.pattern = tbl_key[k];
               if (r.kind == OP_LOOKUP && a.data != MISS_WORD) begin
                  for (int i = 0; i < NSLOT; i++)
                     if (tbl_valid[i] && i != k) tbl_age[i] = tbl_age[i] + 8'd1;
                  tbl_age[k] = 0;
               end
            end
         end
         OP_NEAREST: begin
            n_search++;
            best = 17; k = -1;
            for (int i = 0; i < NSLOT; i++)
               if (tbl_valid[i]) begin
                  d = hamming(r.pattern ^ tbl_key[i]);
                  if (d < best) begin
                     best = d; k = i;
                  end
               end
            if (k < 0) begin
               n_miss++; a.status = ST_MISS;
            end else begin
               n_hit++;
               a.index = 4'(k); a.data = tbl_word[k]; a.pattern = tbl_key[k];
               a.distance = 5'(best);
            end
         end
         OP_STORE, OP_UPDATE: begin
            n_store++;
            k = slot_of_key(r.pattern);
            if (k < 0)
               for (int i = 0; i < NSLOT; i++)
                  if (!tbl_valid[i]) begin
                     k = i; break;
                  end
            if (k < 0 && r.kind == OP_UPDATE) begin
               // evict the oldest, slot 0 when all ages are zero
               top = 0; k = 0;
               for (int i = 0; i < NSLOT; i++)
                  if (tbl_valid[i] && tbl_age[i] > top) begin
                     top = tbl_age[i]; k = i;
                  end
            end
            if (k < 0) begin
               a.status = ST_FULL;
            end else begin
               tbl_valid[k] = 1; tbl_key[k] = r.pattern; tbl_word[k] = r.value; tbl_age[k] = 0;
               a.index = 4'(k); a.data = r.value; a.pattern = r.pattern;
            end
         end
         OP_DELETE: begin
            k = slot_of_key(r.pattern);
            if (k < 0) begin
               a.status = ST_MISS;
            end else begin
               a.index = 4'(k); a.data = tbl_word[k]; a.pattern = tbl_key[k];
               tbl_valid[k] = 0; tbl_key[k] = 0; tbl_word[k] = 0;
            end
         end
         OP_READ: begin
            a.index = r.slot;
            if (tbl_valid[r.slot]) begin
               a.data = tbl_word[r.slot]; a.pattern = tbl_key[r.slot];
            end else begin
               a.status = ST_EMPTY; a.pattern = MISS_WORD;
            end
         end
         default: begin
            wipe_table();
            a.data = '0;
         end
      endcase
      a.hits = n_hit; a.misses = n_miss; a.searches = n_search; a.stores = n_store;
      return a;
   endfunction

   function automatic void add_req(op_type k, logic [15:0] p, logic [15:0] v, logic [3:0] s);
      request_type r;
      r.kind = k; r.pattern = p; r.value = v; r.slot = s;
      pending_reqs.push_back(r);
   endfunction

   // small key pool so searches, deletes and updates find something
   function automatic logic [15:0] pick_key();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 23));
         2: return 16'hFFF0 | 16'($urandom_range(0, 15));
         default: return 16'h5A00 ^ (16'h1 << $urandom_range(0, 15));
      endcase
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return MISS_WORD;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int r;
      op_type k;
      // directed: empty table, fill, full, eviction, all-ones data, read of the last slot
      add_req(OP_READ, 0, 0, 4'd0);
      add_req(OP_NEAREST, 16'h1234, 0, 0);
      add_req(OP_EXACT, 16'h0000, 0, 0);
      add_req(OP_DELETE, 16'hFFFF, 0, 0);
      for (int i = 0; i < 16; i++)
         add_req(OP_STORE, (i == 15) ? 16'hFFFF : 16'(i), (i == 3) ? MISS_WORD : 16'(i * 16'h1111), 0);
      add_req(OP_STORE, 16'hABCD, 16'h1, 0);
      add_req(OP_UPDATE, 16'hABCD, 16'h2, 0);
      add_req(OP_LOOKUP, 16'h0003, 0, 0);
      add_req(OP_LOOKUP, 16'h0005, 0, 0);
      add_req(OP_NEAREST, 16'h8000, 0, 0);
      add_req(OP_UPDATE, 16'h7777, 16'hFFFF, 0);
      add_req(OP_READ, 0, 0, 4'd15);
      add_req(OP_DELETE, 16'h0007, 0, 0);
      add_req(OP_CLEAR, 16'hFFFF, 16'hFFFF, 4'd15);
      for (int n = 0; n < 950; n++) begin
         r = $urandom_range(0, 99);
         if (r < 14) k = OP_EXACT;
         else if (r < 26) k = OP_NEAREST;
         else if (r < 44) k = OP_STORE;
         else if (r < 54) k = OP_DELETE;
         else if (r < 72) k = OP_LOOKUP;
         else if (r < 88) k = OP_UPDATE;
         else if (r < 99) k = OP_READ;
         else k = OP_CLEAR;
         add_req(k, pick_key(), pick_value(), 4'($urandom));
      end
   end

   // sender: bursts and gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_answers.push_back(predict_answer(pending_reqs.pop_front()));
            accepted++;
            op_seen[req_kind]++;
         end
         if (req_valid && req_stall) begin
            // hold the offered request
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 0;
         end else if (pending_reqs.size() > 0) begin
            req_valid <= 1;
            req_kind <= pending_reqs[0].kind;
            req_pattern <= pending_reqs[0].pattern;
            req_value <= pending_reqs[0].value;
            req_slot <= pending_reqs[0].slot;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_valid <= 0;
            stim_done = 1;
         end
      end
   end

   // receiver: own stall pattern with one long hold-off
   int hold_cnt = 0, mode = 0, mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (answered == 40 && hold_cnt == 0) hold_cnt = 400;
         if (hold_cnt > 0) begin
            hold_cnt--;
            if (hold_cnt == 0) hold_cnt = -1;
            rsp_stall <= 1;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 2);
               mode_left = $urandom_range(10, 200);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         answered++;
         if (expected_answers.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            e = expected_answers.pop_front();
            check_field("status", e.status, rsp_status);
            check_field("entry_index", e.index, rsp_entry_index);
            check_field("entry_data", e.data, rsp_entry_data);
            check_field("entry_pattern", e.pattern, rsp_entry_pattern);
            check_field("distance", e.distance, rsp_distance);
            check_field("hit_total", e.hits, rsp_hit_total);
            check_field("miss_total", e.misses, rsp_miss_total);
            check_field("search_total", e.searches, rsp_search_total);
            check_field("store_total", e.stores, rsp_store_total);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      fork
         begin
            wait (stim_done && expected_answers.size() == 0);
            repeat (80) @(posedge clock);
         end
         begin
            wait (idle_cycles >= WATCH_LIMIT);
            $display("timeout: no request or response moved for %0d cycles", WATCH_LIMIT);
            errors++;
         end
      join_any
      $display("%0d requests, %0d responses; ops exact %0d nearest %0d store %0d delete %0d",
         accepted, answered, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("lookup %0d update %0d read %0d clear %0d, with one long response hold-off",
         op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
